[sv/ptx_pkg.sv]
// ----------------------------------------------------------------------------
// ptx_pkg
// Shared types and constants of the perspective transform engine: datapath
// micro-operations, the command and status structs between the controller and
// the datapath, controller states, function codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptx_pkg;

  // function codes of an input item
  localparam logic [1:0] FUNC_PROJECT = 2'd0;
  localparam logic [1:0] FUNC_NCLIP   = 2'd1;
  localparam logic [1:0] FUNC_AVG3    = 2'd2;
  localparam logic [1:0] FUNC_AVG4    = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_ROT0     = 3'd0;
  localparam logic [2:0] REG_ROT1     = 3'd1;
  localparam logic [2:0] REG_ROT2     = 3'd2;
  localparam logic [2:0] REG_TRANS_XY = 3'd3;
  localparam logic [2:0] REG_TRANS_Z  = 3'd4;
  localparam logic [2:0] REG_SCR_OFF  = 3'd5;
  localparam logic [2:0] REG_DEPTH    = 3'd6;
  localparam logic [2:0] REG_AVG      = 3'd7;

  // status flag bit positions
  localparam int FLAG_IR1  = 0;
  localparam int FLAG_ZSAT = 3;
  localparam int FLAG_DIV  = 4;
  localparam int FLAG_SX   = 5;
  localparam int FLAG_SY   = 6;
  localparam int FLAG_IR0  = 7;
  localparam int FLAG_MAC0 = 8;
  localparam int FLAG_MAC  = 9;

  // quotient bits of the perspective divide (numerator is h shifted by 17)
  localparam int DIV_STEPS = 33;

  // last column of each multiply-accumulate sequence, and the last matrix row
  localparam logic [2:0] ROW_LAST_COL  = 3'd2;
  localparam logic [2:0] PRJ_LAST_COL  = 3'd2;
  localparam logic [2:0] CLIP_LAST_COL = 3'd5;
  localparam logic [1:0] ROW_LAST      = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROW_MAC,
    OP_ROW_END,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_PRJ_MAC,
    OP_PRJ_END,
    OP_CLIP_MAC,
    OP_AVG_MAC,
    OP_Z0_END,
    OP_PUBLISH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROW_MAC,
    ST_ROW_END,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_PRJ_MAC,
    ST_PRJ_END,
    ST_CLIP,
    ST_AVG,
    ST_Z0_END,
    ST_PUBLISH
  } ctl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] row;
    logic [2:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/ptx_ctrl.sv]
// ----------------------------------------------------------------------------
// ptx_ctrl
// Sequencer of the engine: steps the datapath through the multiply-accumulate,
// divide and clamp operations of one item and hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ptx_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  ptx_pkg::dp_status_t  status_i,
  output ptx_pkg::dp_cmd_t     cmd_o
);
  import ptx_pkg::*;

  ctl_state_e state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [2:0] col_q, col_d;
  logic [5:0] div_q, div_d;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      div_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      div_q   <= div_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    div_d   = div_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        row_d = '0;
        col_d = '0;
        case (status_i.func)
          FUNC_PROJECT: state_d = ST_ROW_MAC;
          FUNC_NCLIP:   state_d = ST_CLIP;
          default:      state_d = ST_AVG;
        endcase
      end
      ST_ROW_MAC: begin
        if (col_q == ROW_LAST_COL) state_d = ST_ROW_END;
        else col_d = col_q + 3'd1;
      end
      ST_ROW_END: begin
        col_d = '0;
        if (row_q == ROW_LAST) begin
          state_d = ST_DIV_INIT;
        end else begin
          row_d   = row_q + 2'd1;
          state_d = ST_ROW_MAC;
        end
      end
      ST_DIV_INIT: begin
        div_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_q == 6'(DIV_STEPS - 1)) state_d = ST_DIV_END;
        else div_d = div_q + 6'd1;
      end
      ST_DIV_END: begin
        col_d   = '0;
        state_d = ST_PRJ_MAC;
      end
      ST_PRJ_MAC: state_d = ST_PRJ_END;
      ST_PRJ_END: begin
        if (col_q == PRJ_LAST_COL) begin
          state_d = ST_PUBLISH;
        end else begin
          col_d   = col_q + 3'd1;
          state_d = ST_PRJ_MAC;
        end
      end
      ST_CLIP: begin
        if (col_q == CLIP_LAST_COL) state_d = ST_Z0_END;
        else col_d = col_q + 3'd1;
      end
      ST_AVG:    state_d = ST_Z0_END;
      ST_Z0_END: state_d = ST_PUBLISH;
      ST_PUBLISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command to the datapath
  always_comb begin
    cmd_o.row  = row_q;
    cmd_o.col  = col_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_ROW_MAC:  cmd_o.op = OP_ROW_MAC;
      ST_ROW_END:  cmd_o.op = OP_ROW_END;
      ST_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      ST_DIV:      cmd_o.op = OP_DIV_STEP;
      ST_DIV_END:  cmd_o.op = OP_DIV_END;
      ST_PRJ_MAC:  cmd_o.op = OP_PRJ_MAC;
      ST_PRJ_END:  cmd_o.op = OP_PRJ_END;
      ST_CLIP:     cmd_o.op = OP_CLIP_MAC;
      ST_AVG:      cmd_o.op = OP_AVG_MAC;
      ST_Z0_END:   cmd_o.op = OP_Z0_END;
      ST_PUBLISH:  cmd_o.op = status_i.out_free ? OP_PUBLISH : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[sv/ptx_datapath.sv]
// ----------------------------------------------------------------------------
// ptx_datapath
// Configuration registers, Z and XY queues, one shared 18x20 multiplier with
// a 48-bit accumulator, a radix-2 restoring divider, clamps and the output
// register of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ptx_datapath (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ptx_pkg::dp_cmd_t      cmd_i,
  output ptx_pkg::dp_status_t   status_o,
  input  wire                   cfg_write_i,
  input  wire  [2:0]            cfg_index_i,
  input  wire  [63:0]           cfg_data_i,
  input  wire  [1:0]            func_i,
  input  wire  signed [15:0]    vert_x_i,
  input  wire  signed [15:0]    vert_y_i,
  input  wire  signed [15:0]    vert_z_i,
  input  wire                   frac_shift_i,
  input  wire                   out_stall_i,
  output logic                  out_valid_o,
  output logic signed [10:0]    screen_x_o,
  output logic signed [10:0]    screen_y_o,
  output logic [15:0]           depth_o,
  output logic signed [15:0]    ir_one_o,
  output logic signed [15:0]    ir_two_o,
  output logic signed [15:0]    ir_three_o,
  output logic signed [31:0]    acc_one_o,
  output logic signed [31:0]    acc_two_o,
  output logic signed [31:0]    acc_three_o,
  output logic signed [31:0]    acc_zero_o,
  output logic [12:0]           depth_cue_o,
  output logic [9:0]            status_flags_o
);
  import ptx_pkg::*;

  localparam logic signed [47:0] S16_MIN  = -48'sd32768;
  localparam logic signed [47:0] S16_MAX  = 48'sd32767;
  localparam logic signed [47:0] S32_MIN  = -48'sd2147483648;
  localparam logic signed [47:0] S32_MAX  = 48'sd2147483647;
  localparam logic signed [47:0] S44_MIN  = -48'sd8796093022208;
  localparam logic signed [47:0] S44_MAX  = 48'sd8796093022207;
  localparam logic signed [47:0] U16_MAX  = 48'sd65535;
  localparam logic signed [47:0] SCR_MIN  = -48'sd1024;
  localparam logic signed [47:0] SCR_MAX  = 48'sd1023;
  localparam logic signed [47:0] IR0_MAX  = 48'sd4096;
  localparam logic [32:0]        PERSP_MAX = 33'h1FFFF;

  // configuration registers
  logic [47:0] rot_q [3];
  logic [63:0] trans_xy_q, scr_off_q, depth_par_q;
  logic [31:0] trans_z_q, avg_scale_q;

  // captured item and queues
  logic [1:0]         func_q;
  logic signed [15:0] vx_q, vy_q, vz_q;
  logic               frac_q;
  logic [15:0]        zq_q [4];
  logic [21:0]        xyq_q [3];

  // working registers
  logic signed [47:0] acc_q, acc_d;
  logic signed [15:0] ir_q [3];
  logic [31:0]        mac_q [3];
  logic [31:0]        mac0_q;
  logic [15:0]        depth_q;
  logic signed [10:0] sx_q, sy_q;
  logic [12:0]        ir0_q;
  logic [9:0]         flags_q;
  logic [15:0]        rem_q;
  logic [32:0]        quo_q;
  logic [16:0]        persp_q;
  logic               out_valid_q;

  // operand selection
  logic [47:0]        rot_sel;
  logic signed [15:0] coef, vsel;
  logic [31:0]        tr_sel;
  logic signed [10:0] px [3];
  logic signed [10:0] py [3];
  logic [17:0]        z_sum;
  logic signed [17:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [37:0] prod;
  logic signed [47:0] base;
  logic               negate;

  // clamp results
  logic signed [47:0] mac_r, sh12, sh16;
  logic signed [15:0] ir_clamp;
  logic               ir_sat;
  logic [15:0]        z_clamp;
  logic               z_sat;
  logic signed [10:0] scr_clamp;
  logic               scr_sat;
  logic [12:0]        ir0_clamp;
  logic               ir0_sat;
  logic               mac0_ovf, mac44_ovf;

  // divider step and rounding
  logic [16:0] rem_sh;
  logic        div_ge;
  logic [16:0] rem_sub;
  logic [33:0] q_round;

  logic out_free;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px[i] = xyq_q[i][10:0];
      py[i] = xyq_q[i][21:11];
    end
  end

  // matrix coefficient, vertex component and translation of the current row
  always_comb begin
    case (cmd_i.row)
      2'd0:    begin rot_sel = rot_q[0]; tr_sel = trans_xy_q[31:0];  end
      2'd1:    begin rot_sel = rot_q[1]; tr_sel = trans_xy_q[63:32]; end
      default: begin rot_sel = rot_q[2]; tr_sel = trans_z_q;         end
    endcase
    case (cmd_i.col[1:0])
      2'd0:    begin coef = rot_sel[15:0];  vsel = vx_q; end
      2'd1:    begin coef = rot_sel[31:16]; vsel = vy_q; end
      default: begin coef = rot_sel[47:32]; vsel = vz_q; end
    endcase
  end

  assign z_sum = 18'(zq_q[1]) + 18'(zq_q[2]) + 18'(zq_q[3])
               + ((func_q == FUNC_AVG4) ? 18'(zq_q[0]) : 18'd0);

  // multiplier operand and addend selection
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    base   = '0;
    negate = 1'b0;
    case (cmd_i.op)
      OP_ROW_MAC: begin
        mul_a = 18'(coef);
        mul_b = 20'(vsel);
        base  = (cmd_i.col == 3'd0) ? {{4{tr_sel[31]}}, tr_sel, 12'd0} : acc_q;
      end
      OP_PRJ_MAC: begin
        mul_b = $signed({3'b000, persp_q});
        case (cmd_i.col)
          3'd0: begin
            mul_a = 18'(ir_q[0]);
            base  = 48'($signed(scr_off_q[31:0]));
          end
          3'd1: begin
            mul_a = 18'(ir_q[1]);
            base  = 48'($signed(scr_off_q[63:32]));
          end
          default: begin
            mul_a = 18'($signed(depth_par_q[31:16]));
            base  = 48'($signed(depth_par_q[63:32]));
          end
        endcase
      end
      OP_CLIP_MAC: begin
        base   = (cmd_i.col == 3'd0) ? 48'sd0 : acc_q;
        negate = (cmd_i.col > 3'd2);
        case (cmd_i.col)
          3'd0:    begin mul_a = 18'(px[0]); mul_b = 20'(py[1]); end
          3'd1:    begin mul_a = 18'(px[1]); mul_b = 20'(py[2]); end
          3'd2:    begin mul_a = 18'(px[2]); mul_b = 20'(py[0]); end
          3'd3:    begin mul_a = 18'(px[0]); mul_b = 20'(py[2]); end
          3'd4:    begin mul_a = 18'(px[1]); mul_b = 20'(py[0]); end
          default: begin mul_a = 18'(px[2]); mul_b = 20'(py[1]); end
        endcase
      end
      OP_AVG_MAC: begin
        mul_a = (func_q == FUNC_AVG4) ? 18'($signed(avg_scale_q[31:16]))
                                      : 18'($signed(avg_scale_q[15:0]));
        mul_b = $signed({2'b00, z_sum});
      end
      default: ;
    endcase
  end

  // shared multiplier and accumulator adder
  assign prod  = mul_a * mul_b;
  assign acc_d = negate ? (base - 48'(prod)) : (base + 48'(prod));

  // clamps on the accumulator
  always_comb begin
    mac_r     = frac_q ? (acc_q >>> 12) : acc_q;
    sh12      = acc_q >>> 12;
    sh16      = acc_q >>> 16;
    mac44_ovf = (acc_q > S44_MAX) || (acc_q < S44_MIN);
    mac0_ovf  = (acc_q > S32_MAX) || (acc_q < S32_MIN);

    ir_sat   = 1'b1;
    if (mac_r < S16_MIN)      ir_clamp = 16'sh8000;
    else if (mac_r > S16_MAX) ir_clamp = 16'sh7FFF;
    else begin
      ir_clamp = mac_r[15:0];
      ir_sat   = 1'b0;
    end

    z_sat = 1'b1;
    if (sh12 < 48'sd0)        z_clamp = 16'h0000;
    else if (sh12 > U16_MAX)  z_clamp = 16'hFFFF;
    else begin
      z_clamp = sh12[15:0];
      z_sat   = 1'b0;
    end

    scr_sat = 1'b1;
    if (sh16 < SCR_MIN)       scr_clamp = -11'sd1024;
    else if (sh16 > SCR_MAX)  scr_clamp = 11'sd1023;
    else begin
      scr_clamp = sh16[10:0];
      scr_sat   = 1'b0;
    end

    ir0_sat = 1'b1;
    if (sh12 < 48'sd0)        ir0_clamp = 13'd0;
    else if (sh12 > IR0_MAX)  ir0_clamp = 13'd4096;
    else begin
      ir0_clamp = sh12[12:0];
      ir0_sat   = 1'b0;
    end
  end

  // restoring divider step and quotient rounding
  assign rem_sh  = {rem_q, quo_q[32]};
  assign div_ge  = (rem_sh >= {1'b0, depth_q});
  assign rem_sub = rem_sh - {1'b0, depth_q};
  assign q_round = {1'b0, quo_q} + 34'd1;

  assign out_free = !out_valid_q || !out_stall_i;
  assign status_o.func     = func_q;
  assign status_o.out_free = out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]    <= '0;
      rot_q[1]    <= '0;
      rot_q[2]    <= '0;
      trans_xy_q  <= '0;
      trans_z_q   <= '0;
      scr_off_q   <= '0;
      depth_par_q <= '0;
      avg_scale_q <= '0;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        REG_ROT0:     rot_q[0]    <= cfg_data_i[47:0];
        REG_ROT1:     rot_q[1]    <= cfg_data_i[47:0];
        REG_ROT2:     rot_q[2]    <= cfg_data_i[47:0];
        REG_TRANS_XY: trans_xy_q  <= cfg_data_i;
        REG_TRANS_Z:  trans_z_q   <= cfg_data_i[31:0];
        REG_SCR_OFF:  scr_off_q   <= cfg_data_i;
        REG_DEPTH:    depth_par_q <= cfg_data_i;
        REG_AVG:      avg_scale_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // queues and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) zq_q[i] <= '0;
      for (int i = 0; i < 3; i++) xyq_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_ROW_END && cmd_i.row == ROW_LAST) begin
        zq_q[0] <= zq_q[1];
        zq_q[1] <= zq_q[2];
        zq_q[2] <= zq_q[3];
        zq_q[3] <= z_clamp;
      end
      if (cmd_i.op == OP_PRJ_END && cmd_i.col == 3'd1) begin
        xyq_q[0] <= xyq_q[1];
        xyq_q[1] <= xyq_q[2];
        xyq_q[2] <= {scr_clamp, sx_q};
      end
      if (cmd_i.op == OP_PUBLISH) out_valid_q <= 1'b1;
      else if (!out_stall_i)      out_valid_q <= 1'b0;
    end
  end

  // item working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q  <= func_i;
        vx_q    <= vert_x_i;
        vy_q    <= vert_y_i;
        vz_q    <= vert_z_i;
        frac_q  <= frac_shift_i;
        for (int i = 0; i < 3; i++) begin
          ir_q[i]  <= '0;
          mac_q[i] <= '0;
        end
        mac0_q  <= '0;
        depth_q <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
        ir0_q   <= '0;
        flags_q <= '0;
      end
      OP_ROW_MAC, OP_PRJ_MAC, OP_CLIP_MAC, OP_AVG_MAC: acc_q <= acc_d;
      OP_ROW_END: begin
        mac_q[cmd_i.row] <= mac_r[31:0];
        ir_q[cmd_i.row]  <= ir_clamp;
        if (ir_sat)    flags_q[FLAG_IR1 + int'(cmd_i.row)] <= 1'b1;
        if (mac44_ovf) flags_q[FLAG_MAC] <= 1'b1;
        if (cmd_i.row == ROW_LAST) begin
          depth_q <= z_clamp;
          if (z_sat) flags_q[FLAG_ZSAT] <= 1'b1;
        end
      end
      OP_DIV_INIT: begin
        rem_q <= '0;
        quo_q <= {depth_par_q[15:0], 17'd0};
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
        quo_q <= {quo_q[31:0], div_ge};
      end
      OP_DIV_END: begin
        if (depth_q == 16'd0) begin
          persp_q <= PERSP_MAX[16:0];
          flags_q[FLAG_DIV] <= 1'b1;
        end else if (q_round[33:1] > PERSP_MAX) begin
          persp_q <= PERSP_MAX[16:0];
          flags_q[FLAG_DIV] <= 1'b1;
        end else begin
          persp_q <= q_round[17:1];
        end
      end
      OP_PRJ_END: begin
        case (cmd_i.col)
          3'd0: begin
            sx_q <= scr_clamp;
            if (scr_sat) flags_q[FLAG_SX] <= 1'b1;
          end
          3'd1: begin
            sy_q <= scr_clamp;
            if (scr_sat) flags_q[FLAG_SY] <= 1'b1;
          end
          default: begin
            mac0_q <= acc_q[31:0];
            ir0_q  <= ir0_clamp;
            if (mac0_ovf) flags_q[FLAG_MAC0] <= 1'b1;
            if (ir0_sat)  flags_q[FLAG_IR0] <= 1'b1;
          end
        endcase
      end
      OP_Z0_END: begin
        mac0_q <= acc_q[31:0];
        if (mac0_ovf) flags_q[FLAG_MAC0] <= 1'b1;
        if (func_q[1]) begin
          depth_q <= z_clamp;
          if (z_sat) flags_q[FLAG_ZSAT] <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUBLISH) begin
      screen_x_o     <= sx_q;
      screen_y_o     <= sy_q;
      depth_o        <= depth_q;
      ir_one_o       <= ir_q[0];
      ir_two_o       <= ir_q[1];
      ir_three_o     <= ir_q[2];
      acc_one_o      <= mac_q[0];
      acc_two_o      <= mac_q[1];
      acc_three_o    <= mac_q[2];
      acc_zero_o     <= mac0_q;
      depth_cue_o    <= ir0_q;
      status_flags_o <= flags_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/perspective_transform_engine.sv]
// ----------------------------------------------------------------------------
// perspective_transform_engine
// Geometry transform unit: vertex projection, normal clip and average Z.
// ----------------------------------------------------------------------------
// One item is processed at a time on a single shared multiplier. A projection
// runs these steps after its transfer is accepted: a dispatch step, nine
// multiply-accumulates and three row clamps, the one-bit-per-cycle perspective
// divider with its setup and rounding, three multiply-accumulate and clamp
// pairs for screen X, screen Y and the depth cue, and the publish step that
// loads the result register. A normal clip runs six multiply-accumulates and
// an average Z a single one, each followed by a Z0 end step and publish. The
// engine returns to idle after each publish before the next transfer. The
// result waits in an output register, so the next item is accepted while it is
// still stalled; that item's publish waits until the register is free.
// Configuration writes are always ready and must be issued while idle.
`default_nettype none

module perspective_transform_engine (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [2:0]          cfg_index_i,
  input  wire  [63:0]         cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [1:0]          func_i,
  input  wire  signed [15:0]  vert_x_i,
  input  wire  signed [15:0]  vert_y_i,
  input  wire  signed [15:0]  vert_z_i,
  input  wire                 frac_shift_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic signed [10:0]  screen_x_o,
  output logic signed [10:0]  screen_y_o,
  output logic [15:0]         depth_o,
  output logic signed [15:0]  ir_one_o,
  output logic signed [15:0]  ir_two_o,
  output logic signed [15:0]  ir_three_o,
  output logic signed [31:0]  acc_one_o,
  output logic signed [31:0]  acc_two_o,
  output logic signed [31:0]  acc_three_o,
  output logic signed [31:0]  acc_zero_o,
  output logic [12:0]         depth_cue_o,
  output logic [9:0]          status_flags_o
);
  import ptx_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes complete on every valid cycle
  assign cfg_ready_o = 1'b1;

  ptx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptx_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_write_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .vert_x_i       (vert_x_i),
    .vert_y_i       (vert_y_i),
    .vert_z_i       (vert_z_i),
    .frac_shift_i   (frac_shift_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .depth_o        (depth_o),
    .ir_one_o       (ir_one_o),
    .ir_two_o       (ir_two_o),
    .ir_three_o     (ir_three_o),
    .acc_one_o      (acc_one_o),
    .acc_two_o      (acc_two_o),
    .acc_three_o    (acc_three_o),
    .acc_zero_o     (acc_zero_o),
    .depth_cue_o    (depth_cue_o),
    .status_flags_o (status_flags_o)
  );

endmodule

`default_nettype wire
